FILE: rtl/rfpc_pkg.sv
// rfpc_pkg: shared types and constants of the rocket flight phase controller
// holds item structs, configuration struct, phase and register index enums
// no dependencies
package rfpc_pkg;

  typedef enum logic [2:0] {
    PH_PAD            = 3'd0,
    PH_BOOST          = 3'd1,
    PH_COAST          = 3'd2,
    PH_DROGUE_FIRE    = 3'd3,
    PH_DROGUE_DESCENT = 3'd4,
    PH_MAIN_FIRE      = 3'd5,
    PH_MAIN_DESCENT   = 3'd6,
    PH_LANDED         = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    CFG_BOOST_TIME   = 3'd0,
    CFG_DROGUE_DROP  = 3'd1,
    CFG_MIN_DEPLOY   = 3'd2,
    CFG_MAIN_DEPLOY  = 3'd3,
    CFG_FIRE_TIME    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [23:0] altitude;
    logic               altitude_fresh;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         phase;
    logic signed [23:0] apogee_out;
    logic               drogue_fire;
    logic               main_fire;
    logic               ground_lock;
    logic               close_log;
    logic               deploy_skipped;
  } out_item_t;

  typedef struct packed {
    logic [15:0] boost_ms;
    logic [15:0] drogue_drop;
    logic [22:0] min_deploy_altitude;
    logic [22:0] main_deploy_altitude;
    logic [15:0] fire_ms;
  } cfg_t;

  localparam int unsigned CFG_DATA_W = 23;

  localparam logic [15:0] BOOST_TIME_RST  = 16'd3000;
  localparam logic [15:0] DROGUE_DROP_RST = 16'd48;
  localparam logic [22:0] MIN_DEPLOY_RST  = 23'd1600;
  localparam logic [22:0] MAIN_DEPLOY_RST = 23'd4800;
  localparam logic [15:0] FIRE_TIME_RST   = 16'd1000;

  // 4.5 m and 2.0 m in 1/16 m
  localparam logic signed [23:0] LAUNCH_ALT = 24'sd72;
  localparam logic signed [24:0] LAND_BAND  = 25'sd32;

  localparam logic [3:0]  LAUNCH_COUNT  = 4'd10;
  localparam logic [3:0]  DESCENT_COUNT = 4'd10;
  localparam logic [3:0]  MAIN_COUNT    = 4'd3;
  localparam logic [3:0]  LAND_COUNT    = 4'd3;
  localparam logic [3:0]  COUNT_MAX     = 4'd15;
  localparam logic [31:0] CHECK_MS      = 32'd1000;

endpackage

FILE: rtl/rfpc_cfg.sv
// rfpc_cfg: configuration register file of the flight phase controller
// depends on rfpc_pkg
module rfpc_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [2:0]                         wr_index_i,
  input  logic [rfpc_pkg::CFG_DATA_W-1:0]    wr_data_i,
  output rfpc_pkg::cfg_t                     cfg_o
);

  rfpc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        rfpc_pkg::CFG_BOOST_TIME:  cfg_d.boost_ms             = wr_data_i[15:0];
        rfpc_pkg::CFG_DROGUE_DROP: cfg_d.drogue_drop          = wr_data_i[15:0];
        rfpc_pkg::CFG_MIN_DEPLOY:  cfg_d.min_deploy_altitude  = wr_data_i[22:0];
        rfpc_pkg::CFG_MAIN_DEPLOY: cfg_d.main_deploy_altitude = wr_data_i[22:0];
        rfpc_pkg::CFG_FIRE_TIME:   cfg_d.fire_ms              = wr_data_i[15:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boost_ms             <= rfpc_pkg::BOOST_TIME_RST;
      cfg_q.drogue_drop          <= rfpc_pkg::DROGUE_DROP_RST;
      cfg_q.min_deploy_altitude  <= rfpc_pkg::MIN_DEPLOY_RST;
      cfg_q.main_deploy_altitude <= rfpc_pkg::MAIN_DEPLOY_RST;
      cfg_q.fire_ms              <= rfpc_pkg::FIRE_TIME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/rfpc_seq.sv
// rfpc_seq: flight phase state machine, apogee tracking and landing checks
// one item is processed per cycle when step_i is high
// depends on rfpc_pkg
module rfpc_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  rfpc_pkg::in_item_t   item_i,
  input  rfpc_pkg::cfg_t       cfg_i,
  output rfpc_pkg::out_item_t  result_o
);

  rfpc_pkg::phase_e   phase_q, phase_d;
  logic [3:0]         count_q, count_d;
  logic [31:0]        start_q, start_d;
  logic               entered_q, entered_d;
  logic signed [23:0] apogee_q, apogee_d;
  logic signed [23:0] lca_q, lca_d;
  logic [31:0]        lct_q, lct_d;

  logic [31:0]        now;
  logic signed [23:0] alt;
  logic               fresh;
  logic [3:0]         count_inc;
  logic [31:0]        dt_start;
  logic               launch_up;
  logic signed [23:0] apogee_new;
  logic signed [25:0] alt26;
  logic signed [25:0] drop_thr;
  logic               below_drop;
  logic               low_apogee;
  logic               fire_done;
  logic               boost_done;
  logic               below_main;
  logic signed [23:0] lca_eff;
  logic [31:0]        lct_eff;
  logic               check_due;
  logic signed [24:0] alt_diff;
  logic               in_band;
  logic               lock;
  logic               closing;
  logic               skipped;

  assign now   = item_i.now_ms;
  assign alt   = item_i.altitude;
  assign fresh = item_i.altitude_fresh;

  // shared conditions
  always_comb begin
    count_inc  = (count_q == rfpc_pkg::COUNT_MAX) ? count_q : count_q + 4'd1;
    dt_start   = now - start_q;
    launch_up  = alt > rfpc_pkg::LAUNCH_ALT;
    apogee_new = (fresh && (alt > apogee_q)) ? alt : apogee_q;
    alt26      = $signed({{2{alt[23]}}, alt});
    drop_thr   = $signed({{2{apogee_new[23]}}, apogee_new})
               - $signed({10'd0, cfg_i.drogue_drop});
    below_drop = alt26 < drop_thr;
    low_apogee = $signed({apogee_q[23], apogee_q})
               < $signed({2'b00, cfg_i.min_deploy_altitude});
    fire_done  = dt_start >= {16'd0, cfg_i.fire_ms};
    boost_done = dt_start > {16'd0, cfg_i.boost_ms};
    below_main = $signed({alt[23], alt}) < $signed({2'b00, cfg_i.main_deploy_altitude});
    // the entry item of main descent checks against itself
    lca_eff    = entered_q ? lca_q : alt;
    lct_eff    = entered_q ? lct_q : now;
    check_due  = (now - lct_eff) >= rfpc_pkg::CHECK_MS;
    alt_diff   = $signed({alt[23], alt}) - $signed({lca_eff[23], lca_eff});
    in_band    = (alt_diff < rfpc_pkg::LAND_BAND) && (alt_diff > -rfpc_pkg::LAND_BAND);
  end

  // next state
  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    start_d   = start_q;
    entered_d = entered_q;
    apogee_d  = apogee_q;
    lca_d     = lca_q;
    lct_d     = lct_q;
    if (step_i) begin
      unique case (phase_q)
        rfpc_pkg::PH_PAD: begin
          if (fresh) begin
            if (launch_up) begin
              count_d = count_inc;
              if (count_inc >= rfpc_pkg::LAUNCH_COUNT) begin
                phase_d   = rfpc_pkg::PH_BOOST;
                count_d   = '0;
                start_d   = now;
                entered_d = 1'b0;
              end
            end else begin
              count_d = '0;
            end
          end
        end
        rfpc_pkg::PH_BOOST: begin
          if (boost_done) begin
            phase_d   = rfpc_pkg::PH_COAST;
            count_d   = '0;
            start_d   = now;
            entered_d = 1'b0;
          end
        end
        rfpc_pkg::PH_COAST: begin
          if (fresh) begin
            apogee_d = apogee_new;
            if (below_drop) begin
              count_d = count_inc;
              if (count_inc >= rfpc_pkg::DESCENT_COUNT) begin
                phase_d   = rfpc_pkg::PH_DROGUE_FIRE;
                count_d   = '0;
                start_d   = now;
                entered_d = 1'b0;
              end
            end else begin
              count_d = '0;
            end
          end
        end
        rfpc_pkg::PH_DROGUE_FIRE, rfpc_pkg::PH_MAIN_FIRE: begin
          if (!entered_q) begin
            if (low_apogee) begin
              phase_d = (phase_q == rfpc_pkg::PH_DROGUE_FIRE) ?
                        rfpc_pkg::PH_DROGUE_DESCENT : rfpc_pkg::PH_MAIN_DESCENT;
              count_d = '0;
              start_d = now;
            end else begin
              start_d   = now;
              entered_d = 1'b1;
            end
          end else if (fire_done) begin
            phase_d   = (phase_q == rfpc_pkg::PH_DROGUE_FIRE) ?
                        rfpc_pkg::PH_DROGUE_DESCENT : rfpc_pkg::PH_MAIN_DESCENT;
            count_d   = '0;
            start_d   = now;
            entered_d = 1'b0;
          end
        end
        rfpc_pkg::PH_DROGUE_DESCENT: begin
          if (fresh) begin
            if (below_main) begin
              count_d = count_inc;
              if (count_inc >= rfpc_pkg::MAIN_COUNT) begin
                phase_d   = rfpc_pkg::PH_MAIN_FIRE;
                count_d   = '0;
                start_d   = now;
                entered_d = 1'b0;
              end
            end else begin
              count_d = '0;
            end
          end
        end
        rfpc_pkg::PH_MAIN_DESCENT: begin
          entered_d = 1'b1;
          lca_d     = lca_eff;
          lct_d     = lct_eff;
          if (check_due) begin
            lca_d = alt;
            lct_d = now;
            if (in_band) begin
              count_d = count_inc;
              if (count_inc >= rfpc_pkg::LAND_COUNT) begin
                phase_d   = rfpc_pkg::PH_LANDED;
                count_d   = '0;
                start_d   = now;
                entered_d = 1'b0;
              end
            end else begin
              count_d = '0;
            end
          end
        end
        rfpc_pkg::PH_LANDED: begin
          entered_d = 1'b1;
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // result of the item, taken after the update
  always_comb begin
    lock    = (phase_q == rfpc_pkg::PH_PAD) && fresh && launch_up
            && (count_inc >= rfpc_pkg::LAUNCH_COUNT);
    closing = (phase_q == rfpc_pkg::PH_LANDED) && !entered_q;
    skipped = ((phase_q == rfpc_pkg::PH_DROGUE_FIRE) || (phase_q == rfpc_pkg::PH_MAIN_FIRE))
            && !entered_q && low_apogee;
    result_o.phase          = phase_d;
    result_o.apogee_out     = apogee_d;
    result_o.drogue_fire    = (phase_d == rfpc_pkg::PH_DROGUE_FIRE) && entered_d;
    result_o.main_fire      = (phase_d == rfpc_pkg::PH_MAIN_FIRE) && entered_d;
    result_o.ground_lock    = lock;
    result_o.close_log      = closing;
    result_o.deploy_skipped = skipped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rfpc_pkg::PH_PAD;
      count_q   <= '0;
      start_q   <= '0;
      entered_q <= 1'b0;
      apogee_q  <= '0;
      lca_q     <= '0;
      lct_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      start_q   <= start_d;
      entered_q <= entered_d;
      apogee_q  <= apogee_d;
      lca_q     <= lca_d;
      lct_q     <= lct_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != $past(phase_q)) |-> (phase_q > $past(phase_q)))
    else $error("flight phase moved backward");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(phase_q) && $stable(apogee_q) && $stable(count_q)))
    else $error("state changed without an item");

  a_apogee_coast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apogee_q != $past(apogee_q)) |->
      (($past(phase_q) == rfpc_pkg::PH_COAST) && (apogee_q > $past(apogee_q))))
    else $error("apogee changed outside coast or fell");

  a_lock_boost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.ground_lock) |=> (phase_q == rfpc_pkg::PH_BOOST))
    else $error("ground lock without entering boost");
`endif

endmodule

FILE: rtl/rocket_flight_phase_controller.sv
// the result of an item is registered twice: first the input register, then the result register;
// a held result can keep the item waiting in the input register
// throughput: one item per cycle; the phase update is a single pass of compare/subtract logic
// between the input register and the result register; a held result stalls the input side
// reset (rst_ni low, asynchronous): phase pad, all counters, times and apogee zero,
// configuration registers at their defaults; configuration writes are always accepted
module rocket_flight_phase_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // item input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  rfpc_pkg::in_item_t               in_item_i,
  // result output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rfpc_pkg::out_item_t              out_item_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [2:0]                       cfg_index_i,
  input  logic [rfpc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  rfpc_pkg::cfg_t      cfg;
  rfpc_pkg::in_item_t  in_item_q;
  rfpc_pkg::out_item_t result;
  rfpc_pkg::out_item_t out_item_q;
  logic                in_valid_q, in_valid_d;
  logic                out_valid_q, out_valid_d;
  logic                step;
  logic                in_take;

  // registers always take a write
  assign cfg_ready_o = 1'b1;

  rfpc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // the held item is processed when the result register is free or being drained
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  // input register refills whenever it is empty or its item moves on this cycle
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = in_take || (in_valid_q && !step);
    out_valid_d = step || (out_valid_q && out_stall_i);
  end

  rfpc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: tb/sv/tb.sv
// tb: self-checking testbench for rocket_flight_phase_controller, one complete flight
// holds a flight scoreboard class with its own phase predictor, plus driver and sink processes
// depends on rfpc_pkg and the rocket_flight_phase_controller rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 550;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int MAX_PRINTS = 100;

  // predicts one result per accepted item and checks results in order
  class flight_scoreboard;
    rfpc_pkg::cfg_t      cfg;
    rfpc_pkg::phase_e    phase;
    logic [3:0]          confirm;
    logic [31:0]         phase_t0;
    bit                  entered;
    logic signed [23:0]  apogee;
    logic signed [23:0]  check_alt;
    logic [31:0]         check_t;
    rfpc_pkg::out_item_t expected_q[$];
    int                  errors;
    int                  checked;
    int                  accepted;
    int                  locks;
    int                  skips;
    int                  closes;

    function new();
      cfg = '{rfpc_pkg::BOOST_TIME_RST, rfpc_pkg::DROGUE_DROP_RST, rfpc_pkg::MIN_DEPLOY_RST,
              rfpc_pkg::MAIN_DEPLOY_RST, rfpc_pkg::FIRE_TIME_RST};
      phase     = rfpc_pkg::PH_PAD;
      confirm   = '0;
      phase_t0  = '0;
      entered   = 1'b0;
      apogee    = '0;
      check_alt = '0;
      check_t   = '0;
      errors    = 0;
      checked   = 0;
      accepted  = 0;
      locks     = 0;
      skips     = 0;
      closes    = 0;
    endfunction

    function int to_int(logic [23:0] v);
      return {{8{v[23]}}, v};
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(rfpc_pkg::cfg_idx_e idx, logic [22:0] v);
      case (idx)
        rfpc_pkg::CFG_BOOST_TIME:  cfg.boost_ms             = v[15:0];
        rfpc_pkg::CFG_DROGUE_DROP: cfg.drogue_drop          = v[15:0];
        rfpc_pkg::CFG_MIN_DEPLOY:  cfg.min_deploy_altitude  = v;
        rfpc_pkg::CFG_MAIN_DEPLOY: cfg.main_deploy_altitude = v;
        rfpc_pkg::CFG_FIRE_TIME:   cfg.fire_ms              = v[15:0];
        default: ;
      endcase
    endfunction

    function void bump();
      if (confirm != rfpc_pkg::COUNT_MAX) confirm = confirm + 4'd1;
    endfunction

    function void advance_to(rfpc_pkg::phase_e nxt, logic [31:0] now);
      confirm  = '0;
      phase_t0 = now;
      entered  = 1'b0;
      phase    = nxt;
    endfunction

    // charge phases: light on entry unless apogee is too low, then hold for the fire time
    function bit charge_step(logic [31:0] now, rfpc_pkg::phase_e after);
      logic [31:0] dt;
      charge_step = 1'b0;
      dt = now - phase_t0;
      if (!entered) begin
        if (to_int(apogee) < int'({9'd0, cfg.min_deploy_altitude})) begin
          charge_step = 1'b1;
          advance_to(after, now);
        end else begin
          phase_t0 = now;
          entered  = 1'b1;
        end
      end else if (dt >= {16'd0, cfg.fire_ms}) begin
        advance_to(after, now);
      end
    endfunction

    function rfpc_pkg::out_item_t predict_flight(rfpc_pkg::in_item_t it);
      rfpc_pkg::out_item_t r;
      int                  alt;
      int                  diff;
      logic [31:0]         now;
      logic [31:0]         dt;
      bit                  lock;
      bit                  closing;
      bit                  skipped;
      now     = it.now_ms;
      alt     = to_int(it.altitude);
      lock    = 1'b0;
      closing = 1'b0;
      skipped = 1'b0;
      case (phase)
        rfpc_pkg::PH_PAD: begin
          if (it.altitude_fresh) begin
            if (alt > to_int(rfpc_pkg::LAUNCH_ALT)) begin
              bump();
              if (confirm >= rfpc_pkg::LAUNCH_COUNT) begin
                lock = 1'b1;
                advance_to(rfpc_pkg::PH_BOOST, now);
              end
            end else begin
              confirm = '0;
            end
          end
        end
        rfpc_pkg::PH_BOOST: begin
          dt = now - phase_t0;
          if (dt > {16'd0, cfg.boost_ms}) advance_to(rfpc_pkg::PH_COAST, now);
        end
        rfpc_pkg::PH_COAST: begin
          if (it.altitude_fresh) begin
            if (alt > to_int(apogee)) apogee = it.altitude;
            if (alt < to_int(apogee) - int'({16'd0, cfg.drogue_drop})) begin
              bump();
              if (confirm >= rfpc_pkg::DESCENT_COUNT) advance_to(rfpc_pkg::PH_DROGUE_FIRE, now);
            end else begin
              confirm = '0;
            end
          end
        end
        rfpc_pkg::PH_DROGUE_FIRE: skipped = charge_step(now, rfpc_pkg::PH_DROGUE_DESCENT);
        rfpc_pkg::PH_DROGUE_DESCENT: begin
          if (it.altitude_fresh) begin
            if (alt < int'({9'd0, cfg.main_deploy_altitude})) begin
              bump();
              if (confirm >= rfpc_pkg::MAIN_COUNT) advance_to(rfpc_pkg::PH_MAIN_FIRE, now);
            end else begin
              confirm = '0;
            end
          end
        end
        rfpc_pkg::PH_MAIN_FIRE: skipped = charge_step(now, rfpc_pkg::PH_MAIN_DESCENT);
        rfpc_pkg::PH_MAIN_DESCENT: begin
          if (!entered) begin
            check_alt = it.altitude;
            check_t   = now;
            entered   = 1'b1;
          end
          dt = now - check_t;
          if (dt >= rfpc_pkg::CHECK_MS) begin
            diff = alt - to_int(check_alt);
            if (diff < 0) diff = -diff;
            if (diff < int'(rfpc_pkg::LAND_BAND)) begin
              bump();
              if (confirm >= rfpc_pkg::LAND_COUNT) advance_to(rfpc_pkg::PH_LANDED, now);
            end else begin
              confirm = '0;
            end
            check_alt = it.altitude;
            check_t   = now;
          end
        end
        default: begin
          if (!entered) begin
            closing = 1'b1;
            entered = 1'b1;
          end
        end
      endcase
      locks  += lock;
      skips  += skipped;
      closes += closing;
      r.phase          = phase;
      r.apogee_out     = apogee;
      r.drogue_fire    = (phase == rfpc_pkg::PH_DROGUE_FIRE) && entered;
      r.main_fire      = (phase == rfpc_pkg::PH_MAIN_FIRE) && entered;
      r.ground_lock    = lock;
      r.close_log      = closing;
      r.deploy_skipped = skipped;
      return r;
    endfunction

    function void note_input(rfpc_pkg::in_item_t it);
      accepted++;
      expected_q.push_back(predict_flight(it));
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("ERROR: %s", msg);
      errors++;
    endtask

    task compare(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d field %s got %0h expected %0h", checked, field, got, want));
    endtask

    task check(rfpc_pkg::out_item_t got);
      rfpc_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report("result arrived with no item outstanding");
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare("phase", got.phase, want.phase);
      compare("apogee_out", got.apogee_out, want.apogee_out);
      compare("drogue_fire", got.drogue_fire, want.drogue_fire);
      compare("main_fire", got.main_fire, want.main_fire);
      compare("ground_lock", got.ground_lock, want.ground_lock);
      compare("close_log", got.close_log, want.close_log);
      compare("deploy_skipped", got.deploy_skipped, want.deploy_skipped);
    endtask
  endclass

  // clock, reset and block ports; the driven inputs are known from time zero
  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  rfpc_pkg::in_item_t              in_item   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  rfpc_pkg::out_item_t             out_item;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [2:0]                      cfg_index = '0;
  logic [rfpc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic [31:0]      now_t;
  int               cfg_writes = 0;
  flight_scoreboard sb = new();

  always #2 clk = ~clk;

  rocket_flight_phase_controller DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // altitude clipped into the signed 24 bit field
  function automatic logic [23:0] to_alt(int v);
    if (v > 8388607) return 24'h7FFFFF;
    if (v < -8388608) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic int any_alt();
    return int'($urandom_range(0, 16777215)) - 8388608;
  endfunction

  function automatic int spread(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic rfpc_pkg::in_item_t mk(logic [31:0] t, int a, bit f);
    rfpc_pkg::in_item_t it;
    it.now_ms         = t;
    it.altitude       = to_alt(a);
    it.altitude_fresh = f;
    return it;
  endfunction

  // zero and full scale come up often so the register extremes get exercised
  function automatic logic [22:0] pick_value(int bits);
    logic [31:0] top;
    int          r;
    top = (32'd1 << bits) - 32'd1;
    r   = $urandom_range(0, 3);
    if (r == 0) return '0;
    if (r == 1) return top[22:0];
    return top[22:0] & 23'($urandom);
  endfunction

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // items spent in a phase before the stimulus starts pushing toward the next one
  function automatic int phase_budget(rfpc_pkg::phase_e p);
    case (p)
      rfpc_pkg::PH_PAD:            return 90;
      rfpc_pkg::PH_BOOST:          return 50;
      rfpc_pkg::PH_COAST:          return 110;
      rfpc_pkg::PH_DROGUE_FIRE:    return 2;
      rfpc_pkg::PH_DROGUE_DESCENT: return 70;
      rfpc_pkg::PH_MAIN_FIRE:      return 30;
      rfpc_pkg::PH_MAIN_DESCENT:   return 110;
      default:                     return 60;
    endcase
  endfunction

  // next item for the phase the flight is in; push mode drives the confirming condition
  function automatic rfpc_pkg::in_item_t make_item(rfpc_pkg::phase_e p, bit push);
    rfpc_pkg::in_item_t it;
    int                 a;
    int                 r;
    int                 step;
    r    = $urandom_range(0, 99);
    step = (r < 5) ? $urandom_range(0, 2000) : $urandom_range(0, 60);
    it.altitude_fresh = ($urandom_range(0, 99) < 75);
    case (p)
      rfpc_pkg::PH_PAD: begin
        now_t = (r < 3) ? $urandom : now_t + step;
        if (push) begin
          a = spread(73, 5000);
          it.altitude_fresh = 1'b1;
        end else if (r < 20) begin
          a = any_alt();
        end else begin
          // straddles the launch threshold so counts build and clear
          a = spread(40, 105);
        end
      end
      rfpc_pkg::PH_BOOST, rfpc_pkg::PH_DROGUE_FIRE, rfpc_pkg::PH_MAIN_FIRE: begin
        // a push step is beyond any 16 bit boost or fire time
        now_t = now_t + (push ? $urandom_range(65536, 100000) : step);
        a     = any_alt();
      end
      rfpc_pkg::PH_COAST: begin
        now_t = (r < 3) ? $urandom : now_t + step;
        if (push) begin
          a = spread(-8388608, -8387608);
          it.altitude_fresh = 1'b1;
        end else if (r < 8) begin
          // stays clear of full scale so apogee can sit below the largest minimum
          a = spread(-8388608, 8000000);
        end else begin
          a = sb.to_int(sb.apogee) + spread(-100, 40);
        end
      end
      rfpc_pkg::PH_DROGUE_DESCENT: begin
        now_t = (r < 3) ? $urandom : now_t + step;
        if (push) begin
          a = spread(-8388608, -8288608);
          it.altitude_fresh = 1'b1;
        end else if (r < 8) begin
          a = any_alt();
        end else begin
          a = int'({9'd0, sb.cfg.main_deploy_altitude}) + spread(-2, 10);
        end
      end
      rfpc_pkg::PH_MAIN_DESCENT: begin
        if (push) begin
          now_t = now_t + $urandom_range(1000, 1400);
          a     = sb.to_int(sb.check_alt) + spread(-31, 31);
        end else begin
          now_t = now_t + ((r < 50) ? $urandom_range(0, 400) : $urandom_range(900, 1500));
          a     = (r < 3) ? any_alt() : sb.to_int(sb.check_alt) + spread(-40, 40);
        end
      end
      default: begin
        now_t = $urandom;
        a     = any_alt();
      end
    endcase
    it.now_ms   = now_t;
    it.altitude = to_alt(a);
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task send_item(rfpc_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write of a batch
  task write_reg(rfpc_pkg::cfg_idx_e idx, logic [22:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
  endtask

  task write_all_random();
    write_reg(rfpc_pkg::CFG_BOOST_TIME, pick_value(16));
    write_reg(rfpc_pkg::CFG_DROGUE_DROP, pick_value(16));
    write_reg(rfpc_pkg::CFG_MIN_DEPLOY, pick_value(23));
    write_reg(rfpc_pkg::CFG_MAIN_DEPLOY, pick_value(23));
    write_reg(rfpc_pkg::CFG_FIRE_TIME, pick_value(16));
  endtask

  // sender holds off until every result is back, then retunes the registers
  // that matter for the phase the flight is in
  task settle_and_configure(rfpc_pkg::phase_e p, bit mid);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    case (p)
      rfpc_pkg::PH_PAD:            if (mid) write_all_random();
      rfpc_pkg::PH_BOOST:
        write_reg(rfpc_pkg::CFG_BOOST_TIME, mid ? pick_value(16) : 23'd65535);
      rfpc_pkg::PH_COAST:          write_reg(rfpc_pkg::CFG_DROGUE_DROP, pick_value(16));
      // apogee stays under full scale, so the drogue charge gets skipped
      rfpc_pkg::PH_DROGUE_FIRE:    write_reg(rfpc_pkg::CFG_MIN_DEPLOY, 23'h7FFFFF);
      rfpc_pkg::PH_DROGUE_DESCENT: begin
        write_reg(rfpc_pkg::CFG_MAIN_DEPLOY, pick_value(23));
        // apogee is never negative, so the main charge lights
        if (!mid) write_reg(rfpc_pkg::CFG_MIN_DEPLOY, 23'd0);
      end
      // longest fire time first, then zero ends the charge on the next item
      rfpc_pkg::PH_MAIN_FIRE:
        write_reg(rfpc_pkg::CFG_FIRE_TIME, mid ? 23'd0 : 23'd65535);
      rfpc_pkg::PH_MAIN_DESCENT:
        write_reg(mid ? rfpc_pkg::CFG_DROGUE_DROP : rfpc_pkg::CFG_BOOST_TIME, pick_value(16));
      default:
        write_reg(mid ? rfpc_pkg::CFG_MAIN_DEPLOY : rfpc_pkg::CFG_FIRE_TIME,
                  pick_value(mid ? 23 : 16));
    endcase
    cfg_valid <= 1'b0;
  endtask

  // result sink: samples at the rising edge, before the block updates its outputs
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_item);
  end

  // result side stall pattern, with one long hold-off so the block backs up
  initial begin : result_stall
    int   hold_left;
    int   run_left;
    int   r;
    bit   long_done;
    logic stall_next;
    hold_left = 0;
    run_left  = 0;
    long_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_done && sb.checked >= 200) begin
        long_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        stall_next = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          run_left   = $urandom_range(1, 25);
          stall_next = 1'b0;
        end else if (r < 92) begin
          hold_left  = $urandom_range(0, 2);
          stall_next = 1'b1;
        end else begin
          hold_left  = $urandom_range(8, 40);
          stall_next = 1'b1;
        end
      end
      out_stall <= stall_next;
    end
  end

  // stimulus: a short directed pad sequence, then one whole flight steered by the predictor
  initial begin : stimulus
    int               n;
    int               in_phase;
    int               waited;
    rfpc_pkg::phase_e cur;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    write_all_random();
    cfg_valid <= 1'b0;

    // field extremes and the launch counter: clear on a low fresh sample,
    // hold on samples that are not fresh
    send_item(mk(32'd0, -8388608, 1'b1));
    send_item(mk(32'hFFFF_FFFF, 8388607, 1'b1));
    send_item(mk(32'd5, 73, 1'b1));
    send_item(mk(32'd9, 8388607, 1'b0));
    send_item(mk(32'd12, -8388608, 1'b0));
    for (n = 0; n < 7; n++) send_item(mk(32'd20 + n, 73 + n * 1000, 1'b1));
    send_item(mk(32'd40, 72, 1'b1));
    send_item(mk(32'd41, 73, 1'b1));
    send_item(mk(32'd42, 0, 1'b1));
    send_item(mk(32'd43, -1, 1'b0));

    // start close to the top of the clock so time differences wrap mid flight
    now_t    = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
    cur      = sb.phase;
    in_phase = 0;
    for (n = 0; n < N_RANDOM; n++) begin
      if (sb.phase != cur) begin
        cur      = sb.phase;
        in_phase = 0;
        settle_and_configure(cur, 1'b0);
      end else if (phase_budget(cur) >= 10 && in_phase == phase_budget(cur) / 2) begin
        settle_and_configure(cur, 1'b1);
      end
      send_item(make_item(cur, in_phase >= phase_budget(cur)));
      in_phase++;
    end
    in_valid <= 1'b0;

    // drain, then let the two register stages (input and result) empty
    for (waited = 0; waited < 5000 && sb.pending() != 0; waited++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("summary: %0d items, %0d results checked, %0d register writes",
             sb.accepted, sb.checked, cfg_writes);
    $display("summary: flight ended in %s, ground locks %0d, charge skips %0d, log closes %0d",
             sb.phase.name(), sb.locks, sb.skips, sb.closes);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout: stimulus or results did not complete");
    $display("Mismatches found");
    $finish;
  end

endmodule
